FILE: rtl/euler_zyx_to_rotation_matrix_defines.svh
// Assertion helpers for the Euler-to-matrix block.
// Both expect i_clk and i_rst_n in the scope of use.
`ifndef EULER_ZYX_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ZYX_TO_ROTATION_MATRIX_DEFINES_SVH

// same-cycle implication
`define EZR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ezr: same-cycle check failed");

// next-cycle implication
`define EZR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ezr: next-cycle check failed");

`endif

FILE: rtl/ezr_pkg.sv
`timescale 1ns / 1ps

package ezr_pkg;

    localparam int CORDIC_STEPS_DEF  = 14;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int MAX_STEPS         = 24;
    localparam int MIN_GAIN_STEPS    = 8;

    localparam int AW    = 16;      // angle field width
    localparam int FW    = 16;      // matrix entry field width
    localparam int QW    = 32;      // Q2.30 sine / cosine / product width
    localparam int ZW    = 33;      // Q2.29 residual angle width, with headroom
    localparam int SW    = QW + 1;  // width of a two-term sum
    localparam int LANES = 3;

    localparam int LANE_Z = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_X = 2;

    localparam logic signed [ZW-1:0] HALF_PI_Q29 = 33'sd843314857;
    localparam logic signed [ZW-1:0] PI_Q29      = 33'sd1686629713;

    // atan(2^-i), Q2.29
    localparam logic [QW-1:0] ATAN_Q29 [MAX_STEPS] = '{
        32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579,
        32'd33510843,  32'd16771758,  32'd8387925,   32'd4194219,
        32'd2097141,   32'd1048575,   32'd524288,    32'd262144,
        32'd131072,    32'd65536,     32'd32768,     32'd16384,
        32'd8192,      32'd4096,      32'd2048,      32'd1024,
        32'd512,       32'd256,       32'd128,       32'd64
    };

    // CORDIC gain compensation, Q2.30, for 8 to 24 iterations
    localparam logic [QW-1:0] GAIN_Q30 [MAX_STEPS - MIN_GAIN_STEPS + 1] = '{
        32'd652039507, 32'd652034532, 32'd652033289, 32'd652032978,
        32'd652032900, 32'd652032881, 32'd652032876, 32'd652032874,
        32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874,
        32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874,
        32'd652032874
    };

    function automatic int clamp_steps(input int steps);
        return (steps > MAX_STEPS) ? MAX_STEPS : steps;
    endfunction

    function automatic logic signed [QW-1:0] gain_q30(input int steps);
        int n;
        n = clamp_steps(steps);
        n = (n < MIN_GAIN_STEPS) ? 0 : n - MIN_GAIN_STEPS;
        return $signed(GAIN_Q30[n]);
    endfunction

    typedef struct packed {
        logic signed [AW-1:0] angle_z;
        logic signed [AW-1:0] angle_y;
        logic signed [AW-1:0] angle_x;
    } t_ang;

    typedef struct packed {
        logic signed [FW-1:0] rot_00;
        logic signed [FW-1:0] rot_01;
        logic signed [FW-1:0] rot_02;
        logic signed [FW-1:0] rot_10;
        logic signed [FW-1:0] rot_11;
        logic signed [FW-1:0] rot_12;
        logic signed [FW-1:0] rot_20;
        logic signed [FW-1:0] rot_21;
        logic signed [FW-1:0] rot_22;
    } t_rot;

    typedef struct packed {
        logic                 flip;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_lane;

    typedef t_lane [LANES-1:0] t_cord;

endpackage

FILE: rtl/ezr_cordic_cell.sv
`timescale 1ns / 1ps

module ezr_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  ezr_pkg::t_cord i_cord,
    output logic          o_valid,
    output ezr_pkg::t_cord o_cord
);

    localparam logic signed [ezr_pkg::ZW-1:0] ANGLE =
        ezr_pkg::ZW'($signed(ezr_pkg::ATAN_Q29[STEP]));

    logic           r_valid;
    ezr_pkg::t_cord r_cord;
    ezr_pkg::t_cord n_cord;

    always_comb begin
        n_cord = i_cord;
        for (int l = 0; l < ezr_pkg::LANES; l++) begin
            if (!i_cord[l].z[ezr_pkg::ZW-1]) begin
                n_cord[l].x = i_cord[l].x - ($signed(i_cord[l].y) >>> STEP);
                n_cord[l].y = i_cord[l].y + ($signed(i_cord[l].x) >>> STEP);
                n_cord[l].z = i_cord[l].z - ANGLE;
            end else begin
                n_cord[l].x = i_cord[l].x + ($signed(i_cord[l].y) >>> STEP);
                n_cord[l].y = i_cord[l].y - ($signed(i_cord[l].x) >>> STEP);
                n_cord[l].z = i_cord[l].z + ANGLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cord <= n_cord;
        end
    end

    assign o_valid = r_valid;
    assign o_cord  = r_cord;

endmodule

FILE: rtl/ezr_mat.sv
`timescale 1ns / 1ps

module ezr_mat #(
    parameter int OUT_FRAC_BITS = ezr_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  ezr_pkg::t_cord i_cord,
    output logic           o_valid,
    output ezr_pkg::t_rot  o_rot
);

    localparam int QW = ezr_pkg::QW;
    localparam int SW = ezr_pkg::SW;
    localparam int VW = SW + 1;
    localparam int SH = 30 - OUT_FRAC_BITS;
    localparam logic signed [VW-1:0] RND = VW'((64'd1 << SH) >> 1);
    localparam logic signed [VW-1:0] LIM = VW'(64'd1 << OUT_FRAC_BITS);

    // Q2.30 product, round half up
    function automatic logic signed [QW-1:0] mul_rnd(
        input logic signed [QW-1:0] a,
        input logic signed [QW-1:0] b
    );
        logic signed [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b);
        p = p + (64'sd1 <<< 29);
        p = p >>> 30;
        return p[QW-1:0];
    endfunction

    function automatic logic signed [ezr_pkg::FW-1:0] finish(
        input logic signed [SW-1:0] s
    );
        logic signed [VW-1:0] v;
        v = VW'(s) + RND;
        v = v >>> SH;
        if (v > LIM) begin
            v = LIM;
        end else if (v < -LIM) begin
            v = -LIM;
        end
        return v[ezr_pkg::FW-1:0];
    endfunction

    // stage 0: undo the half-turn fold
    logic                 r_v0;
    logic signed [QW-1:0] r_sz, r_cz, r_sy, r_cy, r_sx, r_cx;
    // stage 1: pairwise products
    logic                 r_v1;
    logic signed [QW-1:0] r_czcy, r_czsy, r_cxsz, r_szsx, r_czcx;
    logic signed [QW-1:0] r_cysz, r_szsy, r_czsx, r_cysx, r_cycx;
    logic signed [QW-1:0] r_sy1, r_sx1;
    // stage 2: triple products
    logic                 r_v2;
    logic signed [QW-1:0] r_t0, r_t1, r_t2, r_t3;
    logic signed [QW-1:0] r_czcy2, r_cxsz2, r_szsx2, r_czcx2;
    logic signed [QW-1:0] r_cysz2, r_czsx2, r_cysx2, r_cycx2, r_sy2;
    // stage 3: sums
    logic                 r_v3;
    logic signed [SW-1:0] r_s00, r_s01, r_s02, r_s10, r_s11, r_s12;
    logic signed [SW-1:0] r_s20, r_s21, r_s22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sz <= i_cord[ezr_pkg::LANE_Z].flip ? -i_cord[ezr_pkg::LANE_Z].y
                                                  :  i_cord[ezr_pkg::LANE_Z].y;
            r_cz <= i_cord[ezr_pkg::LANE_Z].flip ? -i_cord[ezr_pkg::LANE_Z].x
                                                  :  i_cord[ezr_pkg::LANE_Z].x;
            r_sy <= i_cord[ezr_pkg::LANE_Y].flip ? -i_cord[ezr_pkg::LANE_Y].y
                                                  :  i_cord[ezr_pkg::LANE_Y].y;
            r_cy <= i_cord[ezr_pkg::LANE_Y].flip ? -i_cord[ezr_pkg::LANE_Y].x
                                                  :  i_cord[ezr_pkg::LANE_Y].x;
            r_sx <= i_cord[ezr_pkg::LANE_X].flip ? -i_cord[ezr_pkg::LANE_X].y
                                                  :  i_cord[ezr_pkg::LANE_X].y;
            r_cx <= i_cord[ezr_pkg::LANE_X].flip ? -i_cord[ezr_pkg::LANE_X].x
                                                  :  i_cord[ezr_pkg::LANE_X].x;

            r_czcy <= mul_rnd(r_cz, r_cy);
            r_czsy <= mul_rnd(r_cz, r_sy);
            r_cxsz <= mul_rnd(r_cx, r_sz);
            r_szsx <= mul_rnd(r_sz, r_sx);
            r_czcx <= mul_rnd(r_cz, r_cx);
            r_cysz <= mul_rnd(r_cy, r_sz);
            r_szsy <= mul_rnd(r_sz, r_sy);
            r_czsx <= mul_rnd(r_cz, r_sx);
            r_cysx <= mul_rnd(r_cy, r_sx);
            r_cycx <= mul_rnd(r_cy, r_cx);
            r_sy1  <= r_sy;
            r_sx1  <= r_sx;

            r_t0    <= mul_rnd(r_czsy, r_sx1);
            r_t1    <= mul_rnd(r_czcx, r_sy1);
            r_t2    <= mul_rnd(r_szsy, r_sx1);
            r_t3    <= mul_rnd(r_cxsz, r_sy1);
            r_czcy2 <= r_czcy;
            r_cxsz2 <= r_cxsz;
            r_szsx2 <= r_szsx;
            r_czcx2 <= r_czcx;
            r_cysz2 <= r_cysz;
            r_czsx2 <= r_czsx;
            r_cysx2 <= r_cysx;
            r_cycx2 <= r_cycx;
            r_sy2   <= r_sy1;

            r_s00 <= SW'(r_czcy2);
            r_s01 <= SW'(r_t0) - SW'(r_cxsz2);
            r_s02 <= SW'(r_szsx2) + SW'(r_t1);
            r_s10 <= SW'(r_cysz2);
            r_s11 <= SW'(r_czcx2) + SW'(r_t2);
            r_s12 <= SW'(r_t3) - SW'(r_czsx2);
            r_s20 <= -SW'(r_sy2);
            r_s21 <= SW'(r_cysx2);
            r_s22 <= SW'(r_cycx2);
        end
    end

    assign o_valid      = r_v3;
    assign o_rot.rot_00 = finish(r_s00);
    assign o_rot.rot_01 = finish(r_s01);
    assign o_rot.rot_02 = finish(r_s02);
    assign o_rot.rot_10 = finish(r_s10);
    assign o_rot.rot_11 = finish(r_s11);
    assign o_rot.rot_12 = finish(r_s12);
    assign o_rot.rot_20 = finish(r_s20);
    assign o_rot.rot_21 = finish(r_s21);
    assign o_rot.rot_22 = finish(r_s22);

endmodule

FILE: rtl/euler_zyx_to_rotation_matrix.sv
`timescale 1ns / 1ps
// ZYX Euler angles (Q3.13 radians) in, nine rotation matrix entries out. Takes one angle
// triple per cycle while o_stall is low; each taken beat passes through one fold
// stage, one CORDIC cell per iteration (all three angles side by side), four matrix stages
// (sign restore, pairwise products, triple products, sums), then the output register. An
// output skid stage keeps the pipe moving for one more beat while a result is held; o_stall
// rises only once that skid register is full.

`include "euler_zyx_to_rotation_matrix_defines.svh"

module euler_zyx_to_rotation_matrix #(
    parameter int CORDIC_STEPS  = ezr_pkg::CORDIC_STEPS_DEF,
    parameter int OUT_FRAC_BITS = ezr_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ezr_pkg::t_ang i_angles,
    output logic          o_valid,
    input  logic          i_stall,
    output ezr_pkg::t_rot o_rot
);

    localparam int NSTEP = ezr_pkg::clamp_steps(CORDIC_STEPS);
    localparam logic signed [ezr_pkg::QW-1:0] GAIN = ezr_pkg::gain_q30(CORDIC_STEPS);

    logic en;

    // fold stage
    logic                          r_prep_valid;
    ezr_pkg::t_cord                r_prep;
    ezr_pkg::t_cord                n_prep;
    logic signed [ezr_pkg::AW-1:0] ang [ezr_pkg::LANES];

    logic           v_chain [NSTEP+1];
    ezr_pkg::t_cord c_chain [NSTEP+1];

    logic          m_valid;
    ezr_pkg::t_rot m_rot;

    logic          r_out_valid;
    ezr_pkg::t_rot r_out;
    logic          r_skid_valid;
    ezr_pkg::t_rot r_skid;

    assign en = !r_skid_valid;

    assign ang[ezr_pkg::LANE_Z] = i_angles.angle_z;
    assign ang[ezr_pkg::LANE_Y] = i_angles.angle_y;
    assign ang[ezr_pkg::LANE_X] = i_angles.angle_x;

    // angles past a quarter turn are folded by a half turn; sine and cosine flip sign
    always_comb begin
        for (int l = 0; l < ezr_pkg::LANES; l++) begin
            n_prep[l].x    = GAIN;
            n_prep[l].y    = '0;
            n_prep[l].z    = ezr_pkg::ZW'($signed({ang[l], 16'h0000}));
            n_prep[l].flip = 1'b0;
            if (n_prep[l].z > ezr_pkg::HALF_PI_Q29) begin
                n_prep[l].z    = n_prep[l].z - ezr_pkg::PI_Q29;
                n_prep[l].flip = 1'b1;
            end else if (n_prep[l].z < -ezr_pkg::HALF_PI_Q29) begin
                n_prep[l].z    = n_prep[l].z + ezr_pkg::PI_Q29;
                n_prep[l].flip = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (en) begin
            r_prep_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prep <= n_prep;
        end
    end

    assign v_chain[0] = r_prep_valid;
    assign c_chain[0] = r_prep;

    for (genvar g = 0; g < NSTEP; g++) begin : g_cell
        ezr_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_chain[g]),
            .i_cord  (c_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_cord  (c_chain[g+1])
        );
    end

    ezr_mat #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v_chain[NSTEP]),
        .i_cord  (c_chain[NSTEP]),
        .o_valid (m_valid),
        .o_rot   (m_rot)
    );

    // output register with skid: while the output beat is held, one more beat parks in skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= m_valid;
            end
        end else if (m_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= m_rot;
            end
        end else if (!r_skid_valid) begin
            r_skid <= m_rot;
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_rot   = r_out;

    `EZR_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `EZR_ASSERT_NEXT(a_held_stays, r_out_valid && i_stall, r_out_valid)
    `EZR_ASSERT_NEXT(a_skid_drains, r_skid_valid && !i_stall, r_out_valid && !r_skid_valid)

endmodule
